>>> design/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg: shared types and constants for the Manchester symbol sampler
// Widths, register indexes, reset values and the frame state record.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int TICK_W  = 18;
  localparam int DUR_W   = 15;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 6;
  localparam int WORD_W  = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [IDX_W-1:0] IDX_MAX = 6'd63;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SAMPLE_TICK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TICKS       = 2'd2;

  localparam logic [CFG_W-1:0] FIRST_SAMPLE_TICK_RST = 16'd18;
  localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RST     = 16'd16;
  localparam logic [CFG_W-1:0] FRAME_TICKS_RST       = 16'd567;

  typedef struct packed {
    logic             capture_start;
    logic             first_level;
    logic [DUR_W-1:0] first_duration;
    logic             second_level;
    logic [DUR_W-1:0] second_duration;
  } sym_t;

  typedef struct packed {
    logic [TICK_W-1:0] elapsed;
    logic [TICK_W-1:0] next_tick;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] word;
  } tick_state_t;

  typedef struct packed {
    logic [WORD_W-1:0] frame_word;
    logic [IDX_W-1:0]  bits_sampled;
  } result_t;

endpackage

>>> design/mss_ifs.sv
// ----------------------------------------------------------------------------
// mss_ifs: item channels of the Manchester symbol sampler
// Symbol channel in, frame result channel out, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mss_sym_if;
  logic        valid;
  logic        ready;
  logic        capture_start;
  logic        first_level;
  logic [14:0] first_duration;
  logic        second_level;
  logic [14:0] second_duration;

  modport source (
    output valid, capture_start, first_level, first_duration,
           second_level, second_duration,
    input  ready
  );
  modport sink (
    input  valid, capture_start, first_level, first_duration,
           second_level, second_duration,
    output ready
  );
endinterface

interface mss_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] frame_word;
  logic [5:0]  bits_sampled;

  modport source (
    output valid, frame_word, bits_sampled,
    input  ready
  );
  modport sink (
    input  valid, frame_word, bits_sampled,
    output ready
  );
endinterface

>>> design/mss_half.sv
// ----------------------------------------------------------------------------
// mss_half: one symbol half
// Add the half's duration to the elapsed count and take at most one sample.
// ----------------------------------------------------------------------------
module mss_half
  import mss_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  tick_state_t      st_in,
  input  logic             level,
  input  logic [DUR_W-1:0] duration,
  input  logic [CFG_W-1:0] sample_period,
  output tick_state_t      st_out
);

  logic [TICK_W:0] elapsed_sum;
  logic [TICK_W:0] tick_sum;
  logic [TICK_W-1:0] elapsed_new;
  logic            hit;
  logic            store;
  logic            bit_val;

  assign elapsed_sum = {1'b0, st_in.elapsed} + {{(TICK_W + 1 - DUR_W){1'b0}}, duration};
  assign elapsed_new = elapsed_sum[TICK_W-1:0];
  assign hit         = elapsed_new > st_in.next_tick;
  assign bit_val     = ~level;
  assign store       = hit && (st_in.idx >= IDX_W'(1)) && (st_in.idx <= IDX_W'(WORD_BITS));
  assign tick_sum    = {1'b0, st_in.next_tick} +
                       {{(TICK_W + 1 - CFG_W){1'b0}}, sample_period};

  always_comb begin
    st_out.elapsed   = elapsed_new;
    st_out.next_tick = hit ? tick_sum[TICK_W-1:0] : st_in.next_tick;
    st_out.idx       = (hit && st_in.idx != IDX_MAX) ? st_in.idx + IDX_W'(1) : st_in.idx;
    // sampled bit k lands at word bit k-1
    for (int i = 0; i < WORD_W; i++) begin
      st_out.word[i] = st_in.word[i] | (store && bit_val && (st_in.idx == IDX_W'(i + 1)));
    end
  end

endmodule

>>> design/mss_frame.sv
// ----------------------------------------------------------------------------
// mss_frame: frame state and per-symbol update
// Hold the running frame state, process both halves of a symbol, flag end.
// ----------------------------------------------------------------------------
module mss_frame
  import mss_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  sym_t             sym,
  input  logic [CFG_W-1:0] first_sample_tick,
  input  logic [CFG_W-1:0] sample_period,
  input  logic [CFG_W-1:0] frame_ticks,
  output logic             emit,
  output result_t          result,
  output logic             frame_finished
);

  tick_state_t st;
  tick_state_t st_next;
  tick_state_t st_base;
  tick_state_t st_mid;
  tick_state_t st_end;
  logic        frame_finished_next;
  logic        finished_eff;
  logic        zero_frame;
  logic        done;

  always_comb begin
    if (sym.capture_start) begin
      st_base.elapsed   = '0;
      st_base.next_tick = {{(TICK_W - CFG_W){1'b0}}, first_sample_tick};
      st_base.idx       = '0;
      st_base.word      = '0;
    end else begin
      st_base = st;
    end
  end

  assign finished_eff = sym.capture_start ? 1'b0 : frame_finished;
  assign zero_frame   = sym.capture_start && (frame_ticks == '0);

  mss_half #(.WORD_BITS(WORD_BITS)) u_half0 (
    .st_in         (st_base),
    .level         (sym.first_level),
    .duration      (sym.first_duration),
    .sample_period (sample_period),
    .st_out        (st_mid)
  );

  mss_half #(.WORD_BITS(WORD_BITS)) u_half1 (
    .st_in         (st_mid),
    .level         (sym.second_level),
    .duration      (sym.second_duration),
    .sample_period (sample_period),
    .st_out        (st_end)
  );

  assign done = st_end.elapsed >= {{(TICK_W - CFG_W){1'b0}}, frame_ticks};

  always_comb begin
    st_next             = st;
    frame_finished_next = frame_finished;
    emit                = 1'b0;
    result.frame_word   = st_end.word;
    result.bits_sampled = st_end.idx;
    if (zero_frame) begin
      // empty frame: emit a zero word without touching the symbol
      st_next             = st_base;
      frame_finished_next = 1'b1;
      emit                = 1'b1;
      result.frame_word   = '0;
      result.bits_sampled = '0;
    end else if (!finished_eff) begin
      st_next             = st_end;
      frame_finished_next = done;
      emit                = done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.elapsed     <= '0;
      st.next_tick   <= {{(TICK_W - CFG_W){1'b0}}, FIRST_SAMPLE_TICK_RST};
      st.idx         <= '0;
      st.word        <= '0;
      frame_finished <= 1'b1;
    end else if (fire) begin
      st             <= st_next;
      frame_finished <= frame_finished_next;
    end
  end

endmodule

>>> design/manchester_symbol_sampler_core.sv
// ----------------------------------------------------------------------------
// manchester_symbol_sampler_core: Manchester symbol sampler, top level
// Sample captured line symbols into a frame word and emit it at frame end.
//
//   channel | dir | payload
//   --------+-----+---------------------------------------------------------
//   sym     | in  | capture_start, first/second level and duration
//   res     | out | frame_word, bits_sampled
//   cfg     | in  | cfg_wr_en, cfg_index, cfg_wdata (write only)
//
// One symbol per cycle while the result channel does not stall. A symbol
// passes the input register and then the result register; mss_frame updates
// the frame state for both halves in the same cycle. Reset is synchronous
// and needs no clearing pass.
// A stalled result holds the input register; the sym channel then stalls too.
// ----------------------------------------------------------------------------
module manchester_symbol_sampler_core
  import mss_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  mss_sym_if.sink              sym,
  mss_res_if.source            res,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [CFG_W-1:0] first_sample_tick;
  logic [CFG_W-1:0] sample_period;
  logic [CFG_W-1:0] frame_ticks;

  sym_t    sym_q;
  logic    sym_q_valid;
  logic    proc_fire;
  logic    emit;
  logic    frame_finished;
  result_t result;
  result_t res_q;
  logic    res_q_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_sample_tick <= FIRST_SAMPLE_TICK_RST;
      sample_period     <= SAMPLE_PERIOD_RST;
      frame_ticks       <= FRAME_TICKS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FIRST_SAMPLE_TICK: first_sample_tick <= cfg_wdata;
        CFG_SAMPLE_PERIOD:     sample_period     <= cfg_wdata;
        CFG_FRAME_TICKS:       frame_ticks       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // advance the held item only when the result register can take its word
  assign proc_fire = sym_q_valid && (!res_q_valid || res.ready);
  assign sym.ready = !sym_q_valid || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      sym_q_valid <= 1'b0;
    end else if (sym.ready) begin
      sym_q_valid <= sym.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sym.valid && sym.ready) begin
      sym_q.capture_start   <= sym.capture_start;
      sym_q.first_level     <= sym.first_level;
      sym_q.first_duration  <= sym.first_duration;
      sym_q.second_level    <= sym.second_level;
      sym_q.second_duration <= sym.second_duration;
    end
  end

  mss_frame #(.WORD_BITS(WORD_BITS)) u_frame (
    .clk               (clk),
    .rst               (rst),
    .fire              (proc_fire),
    .sym               (sym_q),
    .first_sample_tick (first_sample_tick),
    .sample_period     (sample_period),
    .frame_ticks       (frame_ticks),
    .emit              (emit),
    .result            (result),
    .frame_finished    (frame_finished)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_q_valid <= 1'b0;
    end else if (proc_fire && emit) begin
      res_q_valid <= 1'b1;
    end else if (res.ready) begin
      res_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && emit) begin
      res_q <= result;
    end
  end

  assign res.valid        = res_q_valid;
  assign res.frame_word   = res_q.frame_word;
  assign res.bits_sampled = res_q.bits_sampled;

`ifndef NO_ASSERTIONS
  // a word never carries bits beyond the last stored sample
  a_word_bits : assert property (@(posedge clk) disable iff (rst)
    res.valid && res.bits_sampled != '0 |->
      (res.frame_word >> (res.bits_sampled - IDX_W'(1))) == '0)
    else $error("frame word has bits beyond the sample count");

  a_word_empty : assert property (@(posedge clk) disable iff (rst)
    res.valid && res.bits_sampled == '0 |-> res.frame_word == '0)
    else $error("empty frame carries a non-zero word");

  // a held item that cannot advance must block the input
  a_hold_blocks : assert property (@(posedge clk) disable iff (rst)
    sym_q_valid && !proc_fire |-> !sym.ready)
    else $error("input taken while held item is stalled");

  a_emit_finishes : assert property (@(posedge clk) disable iff (rst)
    proc_fire && emit |=> frame_finished && res.valid)
    else $error("emitted frame did not close or show its result");
`endif

endmodule
